// ===== design/cpts_pkg.sv =====
// Package for the convex polygon trapezoid splitter.
// Holds sizing constants and status codes.
// No dependencies.
package cpts_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int X_BITS           = 48;
    localparam int Y_BITS           = 32;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_TOO_FEW  = 2'd2;

endpackage

// ===== design/cpts_if.sv =====
// Valid/ready channel interfaces for the trapezoid splitter.
// Field widths are written out in the interfaces; no dependencies.
interface cpts_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;
    modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface cpts_trap_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] left_bottom_x;
    logic signed [47:0] right_bottom_x;
    logic signed [47:0] left_top_x;
    logic signed [47:0] right_top_x;
    logic signed [31:0] bottom_y;
    logic signed [31:0] top_y;
    logic               last_trapezoid;
    logic [1:0]         status;
    modport source (output valid, left_bottom_x, right_bottom_x, left_top_x, right_top_x,
                    bottom_y, top_y, last_trapezoid, status, input ready);
    modport sink (input valid, left_bottom_x, right_bottom_x, left_top_x, right_top_x,
                  bottom_y, top_y, last_trapezoid, status, output ready);
endinterface

// ===== design/cpts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cpts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== design/cpts_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Quotient saturates at 2**62 as the edge interpolation needs. No dependencies.
module cpts_divider #(
    parameter int NUM_BITS = 128,
    parameter int DEN_BITS = 34
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [62:0]         quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] num_reg;
    logic [NUM_BITS-1:0] q_reg;
    logic [DEN_BITS:0]   rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   diff;
    logic                ge;

    assign shifted = {rem_reg[DEN_BITS-1:0], num_reg[NUM_BITS-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
            rem_reg <= ge ? diff : shifted;
            q_reg   <= {q_reg[NUM_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = (|q_reg[NUM_BITS-1:62] && q_reg[NUM_BITS-1:0] > (NUM_BITS'(1) << 62))
                  ? 63'(64'd1 << 62) : q_reg[62:0];
endmodule

// ===== design/cpts_front.sv =====
// Front end: takes vertex beats, writes the vertex stores, counts and
// classifies each polygon, then posts one job to the back end. Depends on cpts_pkg, cpts_if.
module cpts_front #(
    parameter int MAX_VERTICES = cpts_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpts_pkg::COORD_BITS_DEF,
    parameter int IDX_BITS     = $clog2(MAX_VERTICES),
    parameter int CNT_BITS     = $clog2(MAX_VERTICES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    cpts_vertex_if.sink                vin,
    output logic                       wr_en,
    output logic [IDX_BITS-1:0]        wr_addr,
    output logic signed [31:0]         wr_x,
    output logic signed [31:0]         wr_y,
    output logic                       job_valid,
    input  logic                       job_ready,
    output logic [CNT_BITS-1:0]        job_count,
    output logic [1:0]                 job_status
);
    logic [CNT_BITS-1:0] count_reg;
    logic                ovf_reg;
    logic                job_valid_reg;
    logic [CNT_BITS-1:0] job_count_reg;
    logic [1:0]          job_status_reg;
    logic                fire;
    logic                full;
    logic [CNT_BITS-1:0] count_next;
    logic                ovf_next;

    assign vin.ready = !job_valid_reg;
    assign fire      = vin.valid && vin.ready;
    assign full      = count_reg == CNT_BITS'(MAX_VERTICES);
    assign wr_en     = fire && !full;
    assign wr_addr   = count_reg[IDX_BITS-1:0];
    assign wr_x      = 32'(signed'(vin.vertex_x[COORD_BITS-1:0]));
    assign wr_y      = 32'(signed'(vin.vertex_y[COORD_BITS-1:0]));
    assign count_next = full ? count_reg : count_reg + 1'b1;
    assign ovf_next   = ovf_reg || full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            job_valid_reg  <= 1'b0;
            job_count_reg  <= '0;
            job_status_reg <= cpts_pkg::STATUS_OK;
        end
        else
        begin
            if (job_valid_reg && job_ready)
            begin
                job_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                if (vin.last_vertex)
                begin
                    count_reg     <= '0;
                    ovf_reg       <= 1'b0;
                    job_valid_reg <= 1'b1;
                    job_count_reg <= count_next;
                    if (ovf_next)
                    begin
                        job_status_reg <= cpts_pkg::STATUS_OVERFLOW;
                    end
                    else if (count_next < CNT_BITS'(3))
                    begin
                        job_status_reg <= cpts_pkg::STATUS_TOO_FEW;
                    end
                    else
                    begin
                        job_status_reg <= cpts_pkg::STATUS_OK;
                    end
                end
                else
                begin
                    count_reg <= count_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    assign job_valid  = job_valid_reg;
    assign job_count  = job_count_reg;
    assign job_status = job_status_reg;
endmodule

// ===== design/cpts_back.sv =====
// Back end: sequencer that scans the stores, picks the bottom edges and
// sweeps up, using a shared serial divider. Depends on cpts_pkg, cpts_if, cpts_divider.
module cpts_back #(
    parameter int MAX_VERTICES = cpts_pkg::MAX_VERTICES_DEF,
    parameter int FRAC_BITS    = cpts_pkg::FRAC_BITS_DEF,
    parameter int IDX_BITS     = $clog2(MAX_VERTICES),
    parameter int CNT_BITS     = $clog2(MAX_VERTICES + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  logic [CNT_BITS-1:0] job_count,
    input  logic [1:0]          job_status,
    output logic [IDX_BITS-1:0] rd_addr,
    input  logic signed [31:0]  rd_x,
    input  logic signed [31:0]  rd_y,
    cpts_trap_if.source         tout
);
    localparam int NUM_BITS = 128;
    localparam int DEN_BITS = 34;
    localparam logic signed [63:0] X_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] X_MIN = -64'sd140737488355328;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SCAN  = 5'd1;
    localparam logic [4:0] S_SCANW = 5'd2;
    localparam logic [4:0] S_RDA   = 5'd3;
    localparam logic [4:0] S_RDW   = 5'd4;
    localparam logic [4:0] S_PICK  = 5'd5;
    localparam logic [4:0] S_CR1   = 5'd6;
    localparam logic [4:0] S_CR2   = 5'd7;
    localparam logic [4:0] S_INIT  = 5'd8;
    localparam logic [4:0] S_TOPS  = 5'd9;
    localparam logic [4:0] S_TOPW  = 5'd10;
    localparam logic [4:0] S_EDGE  = 5'd11;
    localparam logic [4:0] S_EDGW  = 5'd12;
    localparam logic [4:0] S_MUL   = 5'd13;
    localparam logic [4:0] S_DIV   = 5'd14;
    localparam logic [4:0] S_DIVW  = 5'd15;
    localparam logic [4:0] S_EMIT  = 5'd16;
    localparam logic [4:0] S_STEP  = 5'd17;
    localparam logic [4:0] S_STEPW = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;
    localparam logic [4:0] S_ERR   = 5'd20;

    logic [4:0]          state_reg;
    logic [CNT_BITS-1:0] n_reg;
    logic [CNT_BITS-1:0] ctr_reg;
    logic [IDX_BITS-1:0] imin_reg;
    logic signed [31:0]  ymin_reg;
    logic signed [31:0]  yhi_reg;
    logic [IDX_BITS-1:0] bot_reg;
    logic [IDX_BITS-1:0] lb_reg;
    logic [IDX_BITS-1:0] lt_reg;
    logic [IDX_BITS-1:0] rb_reg;
    logic [IDX_BITS-1:0] rt_reg;
    logic signed [31:0]  vx_reg [4];
    logic signed [31:0]  vy_reg [4];
    logic [2:0]          rd_k_reg;
    logic [2:0]          rd_n_reg;
    logic [IDX_BITS-1:0] ra_reg [4];
    logic signed [32:0]  cm_a_reg;
    logic signed [32:0]  cm_b_reg;
    logic signed [67:0]  cp_reg;
    logic signed [31:0]  sweep_reg;
    logic signed [31:0]  ynew_reg;
    logic [CNT_BITS-1:0] k_reg;
    logic signed [47:0]  pl_reg;
    logic signed [47:0]  pr_reg;
    logic signed [47:0]  lx_reg;
    logic                side_reg;
    logic signed [31:0]  ax_reg;
    logic signed [32:0]  dx_reg;
    logic signed [32:0]  d_reg;
    logic signed [32:0]  t_reg;
    logic [65:0]         prod_reg;
    logic                div_start;
    logic                div_done;
    logic [62:0]         quot;
    logic [NUM_BITS-1:0] div_num;
    logic [DEN_BITS-1:0] div_den;
    logic                out_valid_reg;
    logic [1:0]          ph_reg;

    function automatic logic [IDX_BITS-1:0] wrap_add(input logic [IDX_BITS-1:0] a,
                                                      input logic [CNT_BITS-1:0] d,
                                                      input logic [CNT_BITS-1:0] n);
        logic [CNT_BITS:0] s;
        s = {1'b0, CNT_BITS'(a)} + {1'b0, d};
        if (s >= {1'b0, n})
        begin
            s = s - {1'b0, n};
        end
        return s[IDX_BITS-1:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > X_MAX)
        begin
            return X_MAX[47:0];
        end
        else if (v < X_MIN)
        begin
            return X_MIN[47:0];
        end
        return v[47:0];
    endfunction

    function automatic logic signed [63:0] scl(input logic signed [31:0] x);
        return 64'(x) <<< FRAC_BITS;
    endfunction

    logic [32:0]  dm;
    logic [32:0]  dxm;
    logic [32:0]  tm;
    logic [127:0] nshift;
    logic signed [63:0] off_s;
    logic signed [63:0] ex;
    logic         negq;

    assign dm  = d_reg[32] ? 33'(-d_reg) : 33'(d_reg);
    assign dxm = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign tm  = t_reg[32] ? 33'(-t_reg) : 33'(t_reg);
    assign nshift = ((128'(prod_reg) << FRAC_BITS) << 1) + 128'(dm);
    assign div_num = nshift;
    assign div_den = {dm, 1'b0};
    assign negq  = (dx_reg[32] != t_reg[32]) != d_reg[32];
    assign off_s = negq ? -64'(quot) : 64'(quot);
    assign ex    = scl(ax_reg) + off_s;

    cpts_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quot(quot)
    );

    assign div_start = state_reg == S_DIV;
    assign job_ready = state_reg == S_DONE;

    always_comb
    begin
        rd_addr = ra_reg[rd_k_reg[1:0]];
        if (state_reg == S_SCAN)
        begin
            rd_addr = ctr_reg[IDX_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ctr_reg       <= '0;
            rd_k_reg      <= '0;
            k_reg         <= '0;
        end
        else
        begin
            if (out_valid_reg && tout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        n_reg <= job_count;
                        if (job_status != cpts_pkg::STATUS_OK)
                        begin
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            ctr_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_ERR:
                begin
                    if (!out_valid_reg)
                    begin
                        tout.left_bottom_x  <= '0;
                        tout.right_bottom_x <= '0;
                        tout.left_top_x     <= '0;
                        tout.right_top_x    <= '0;
                        tout.bottom_y       <= '0;
                        tout.top_y          <= '0;
                        tout.last_trapezoid <= 1'b1;
                        tout.status         <= job_status;
                        out_valid_reg       <= 1'b1;
                        state_reg           <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    ctr_reg   <= ctr_reg + 1'b1;
                    state_reg <= S_SCANW;
                end
                S_SCANW:
                begin
                    if (ctr_reg == CNT_BITS'(1))
                    begin
                        ymin_reg <= rd_y;
                        yhi_reg  <= rd_y;
                        imin_reg <= '0;
                    end
                    else
                    begin
                        if (rd_y > yhi_reg)
                        begin
                            yhi_reg <= rd_y;
                        end
                        if (rd_y < ymin_reg)
                        begin
                            ymin_reg <= rd_y;
                            imin_reg <= IDX_BITS'(ctr_reg - 1'b1);
                        end
                    end
                    if (ctr_reg == n_reg)
                    begin
                        ra_reg[0] <= '0;
                        state_reg <= S_RDA;
                        ph_reg    <= 2'd0;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_RDA:
                begin
                    if (ph_reg == 2'd0)
                    begin
                        ra_reg[0] <= wrap_add(imin_reg, n_reg - 1'b1, n_reg);
                        rd_k_reg  <= 3'd0;
                        rd_n_reg  <= 3'd1;
                        ph_reg    <= 2'd1;
                    end
                    else
                    begin
                        ra_reg[0] <= bot_reg;
                        ra_reg[1] <= wrap_add(bot_reg, CNT_BITS'(1), n_reg);
                        ra_reg[2] <= wrap_add(bot_reg, CNT_BITS'(2), n_reg);
                        ra_reg[3] <= wrap_add(bot_reg, n_reg - 1'b1, n_reg);
                        rd_k_reg  <= 3'd0;
                        rd_n_reg  <= 3'd4;
                        ph_reg    <= 2'd2;
                    end
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    rd_k_reg <= rd_k_reg + 1'b1;
                    if (rd_k_reg != 3'd0)
                    begin
                        vx_reg[rd_k_reg[1:0] - 2'd1] <= rd_x;
                        vy_reg[rd_k_reg[1:0] - 2'd1] <= rd_y;
                    end
                    if (rd_k_reg == rd_n_reg)
                    begin
                        if (rd_n_reg == 3'd4)
                        begin
                            state_reg <= S_PICK;
                        end
                        else
                        begin
                            bot_reg   <= (rd_y == ymin_reg) ? ra_reg[0] : imin_reg;
                            state_reg <= S_RDA;
                        end
                    end
                end
                S_PICK:
                begin
                    if (vy_reg[1] == ymin_reg)
                    begin
                        if (vx_reg[2] > vx_reg[3] ||
                            (vx_reg[2] == vx_reg[3] && vx_reg[1] > vx_reg[0]))
                        begin
                            lb_reg <= ra_reg[0]; lt_reg <= ra_reg[3];
                            rb_reg <= ra_reg[1]; rt_reg <= ra_reg[2];
                        end
                        else
                        begin
                            lb_reg <= ra_reg[1]; lt_reg <= ra_reg[2];
                            rb_reg <= ra_reg[0]; rt_reg <= ra_reg[3];
                        end
                        state_reg <= S_INIT;
                    end
                    else
                    begin
                        cm_a_reg  <= 33'(vx_reg[0]) - 33'(vx_reg[3]);
                        cm_b_reg  <= 33'(vy_reg[1]) - 33'(vy_reg[3]);
                        state_reg <= S_CR1;
                    end
                end
                S_CR1:
                begin
                    cp_reg    <= 68'(cm_a_reg) * 68'(cm_b_reg);
                    cm_a_reg  <= 33'(vy_reg[0]) - 33'(vy_reg[3]);
                    cm_b_reg  <= 33'(vx_reg[1]) - 33'(vx_reg[3]);
                    state_reg <= S_CR2;
                end
                S_CR2:
                begin
                    lb_reg <= ra_reg[0];
                    rb_reg <= ra_reg[0];
                    if (cp_reg - 68'(cm_a_reg) * 68'(cm_b_reg) > 0)
                    begin
                        lt_reg <= ra_reg[3]; rt_reg <= ra_reg[1];
                    end
                    else
                    begin
                        lt_reg <= ra_reg[1]; rt_reg <= ra_reg[3];
                    end
                    state_reg <= S_INIT;
                end
                S_INIT:
                begin
                    sweep_reg <= ymin_reg;
                    k_reg     <= '0;
                    pl_reg    <= sat48(scl((lb_reg == ra_reg[0]) ? vx_reg[0] : vx_reg[1]));
                    pr_reg    <= sat48(scl((rb_reg == ra_reg[0]) ? vx_reg[0] : vx_reg[1]));
                    state_reg <= S_TOPS;
                end
                S_TOPS:
                begin
                    if (sweep_reg >= yhi_reg || k_reg == CNT_BITS'(MAX_VERTICES - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ra_reg[0] <= lt_reg;
                        ra_reg[1] <= rt_reg;
                        rd_k_reg  <= 3'd0;
                        state_reg <= S_TOPW;
                    end
                end
                S_TOPW:
                begin
                    if (rd_k_reg != 3'd2)
                    begin
                        rd_k_reg <= rd_k_reg + 1'b1;
                    end
                    if (rd_k_reg == 3'd1)
                    begin
                        vy_reg[0] <= rd_y;
                    end
                    if (rd_k_reg == 3'd2)
                    begin
                        ynew_reg <= (vy_reg[0] < rd_y) ? vy_reg[0] : rd_y;
                        if (((vy_reg[0] < rd_y) ? vy_reg[0] : rd_y) <= sweep_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            side_reg  <= 1'b0;
                            ra_reg[0] <= lb_reg;
                            ra_reg[1] <= lt_reg;
                            rd_k_reg  <= 3'd0;
                            state_reg <= S_EDGW;
                        end
                    end
                end
                S_EDGW:
                begin
                    rd_k_reg <= rd_k_reg + 1'b1;
                    if (rd_k_reg == 3'd1)
                    begin
                        ax_reg <= rd_x;
                        t_reg  <= 33'(ynew_reg) - 33'(rd_y);
                        d_reg  <= -33'(rd_y);
                        dx_reg <= -33'(rd_x);
                    end
                    if (rd_k_reg == 3'd2)
                    begin
                        d_reg     <= d_reg + 33'(rd_y);
                        dx_reg    <= dx_reg + 33'(rd_x);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= 66'(dxm) * 66'(tm);
                    state_reg <= (d_reg == '0) ? S_EMIT : S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!side_reg)
                    begin
                        lx_reg    <= (d_reg == '0) ? sat48(scl(ax_reg)) : sat48(ex);
                        side_reg  <= 1'b1;
                        ra_reg[0] <= rb_reg;
                        ra_reg[1] <= rt_reg;
                        rd_k_reg  <= 3'd0;
                        state_reg <= S_EDGW;
                    end
                    else if (!out_valid_reg)
                    begin
                        tout.left_bottom_x  <= pl_reg;
                        tout.right_bottom_x <= pr_reg;
                        tout.left_top_x     <= lx_reg;
                        tout.right_top_x    <= (d_reg == '0) ? sat48(scl(ax_reg)) : sat48(ex);
                        tout.bottom_y       <= sweep_reg;
                        tout.top_y          <= ynew_reg;
                        tout.status         <= cpts_pkg::STATUS_OK;
                        pl_reg    <= lx_reg;
                        pr_reg    <= (d_reg == '0) ? sat48(scl(ax_reg)) : sat48(ex);
                        sweep_reg <= ynew_reg;
                        k_reg     <= k_reg + 1'b1;
                        ra_reg[0] <= lt_reg;
                        ra_reg[1] <= wrap_add(lt_reg, n_reg - 1'b1, n_reg);
                        ra_reg[2] <= rt_reg;
                        ra_reg[3] <= wrap_add(rt_reg, n_reg - 1'b1, n_reg);
                        rd_k_reg  <= 3'd0;
                        state_reg <= S_STEPW;
                    end
                end
                S_STEPW:
                begin
                    rd_k_reg <= rd_k_reg + 1'b1;
                    if (rd_k_reg != 3'd0)
                    begin
                        vy_reg[rd_k_reg[1:0] - 2'd1] <= rd_y;
                    end
                    if (rd_k_reg == 3'd4)
                    begin
                        if (vy_reg[0] == sweep_reg)
                        begin
                            lb_reg <= lt_reg;
                            lt_reg <= (vy_reg[1] > vy_reg[0]) ? ra_reg[1]
                                      : wrap_add(lt_reg, CNT_BITS'(1), n_reg);
                        end
                        if (vy_reg[2] == sweep_reg)
                        begin
                            rb_reg <= rt_reg;
                            rt_reg <= (rd_y > vy_reg[2]) ? ra_reg[3]
                                      : wrap_add(rt_reg, CNT_BITS'(1), n_reg);
                        end
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (sweep_reg >= yhi_reg || k_reg == CNT_BITS'(MAX_VERTICES - 1))
                    begin
                        tout.last_trapezoid <= 1'b1;
                        out_valid_reg       <= 1'b1;
                        state_reg           <= S_DONE;
                    end
                    else
                    begin
                        ra_reg[0]   <= lt_reg;
                        ra_reg[1]   <= rt_reg;
                        rd_k_reg    <= 3'd0;
                        state_reg   <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    if (rd_k_reg != 3'd2)
                    begin
                        rd_k_reg <= rd_k_reg + 1'b1;
                    end
                    if (rd_k_reg == 3'd1)
                    begin
                        vy_reg[0] <= rd_y;
                    end
                    if (rd_k_reg == 3'd2)
                    begin
                        ynew_reg <= (vy_reg[0] < rd_y) ? vy_reg[0] : rd_y;
                        tout.last_trapezoid <= (((vy_reg[0] < rd_y) ? vy_reg[0] : rd_y)
                                                <= sweep_reg);
                        out_valid_reg <= 1'b1;
                        if (((vy_reg[0] < rd_y) ? vy_reg[0] : rd_y) <= sweep_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            side_reg  <= 1'b0;
                            ra_reg[0] <= lb_reg;
                            ra_reg[1] <= lt_reg;
                            rd_k_reg  <= 3'd0;
                            state_reg <= S_EDGW;
                        end
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign tout.valid = out_valid_reg;
endmodule

// ===== design/convex_polygon_trapezoid_split.sv =====
// Top level of the convex polygon trapezoid splitter.
// Depends on cpts_pkg, cpts_if, cpts_ram, cpts_front, cpts_back.
//
//  channel    dir  payload
//  vin        in   vertex_x, vertex_y, last_vertex
//  tout       out  left/right bottom/top edge x values, bottom_y, top_y, last_trapezoid, status
//
// Vertices load at one beat per cycle while vin is not held off. After
// the last vertex the back end scans the store, then builds each
// trapezoid with up to two serial divisions. Reset is asynchronous,
// active low, and clears control only. The front end holds off vin
// from the last vertex until the back end has finished that polygon,
// since both share the vertex store; tout stalls hold the back end.
module convex_polygon_trapezoid_split #(
    parameter int MAX_VERTICES = cpts_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpts_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS    = cpts_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cpts_vertex_if.sink   vin,
    cpts_trap_if.source   tout
);
    localparam int IDX_BITS = $clog2(MAX_VERTICES);
    localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);

    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic signed [31:0]  wr_x;
    logic signed [31:0]  wr_y;
    logic [IDX_BITS-1:0] rd_addr;
    logic [31:0]         rd_x;
    logic [31:0]         rd_y;
    logic                job_valid;
    logic                job_ready;
    logic [CNT_BITS-1:0] job_count;
    logic [1:0]          job_status;

    cpts_front #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .vin(vin), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_x(wr_x), .wr_y(wr_y), .job_valid(job_valid), .job_ready(job_ready),
        .job_count(job_count), .job_status(job_status)
    );

    cpts_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_xram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_x),
        .rd_addr(rd_addr), .rd_data(rd_x)
    );

    cpts_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_yram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_y),
        .rd_addr(rd_addr), .rd_data(rd_y)
    );

    cpts_back #(.MAX_VERTICES(MAX_VERTICES), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
        .job_count(job_count), .job_status(job_status), .rd_addr(rd_addr),
        .rd_x(signed'(rd_x)), .rd_y(signed'(rd_y)), .tout(tout)
    );
endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for convex_polygon_trapezoid_split: directed and random vertex streams in,
// trapezoids predicted in-bench and compared field by field on the way out.
// Depends on cpts_pkg, cpts_if and the RTL under design/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVERT = cpts_pkg::MAX_VERTICES_DEF;
    localparam int FRAC = cpts_pkg::FRAC_BITS_DEF;
    localparam longint X_HI = (longint'(1) <<< 47) - 1;
    localparam longint X_LO = -(longint'(1) <<< 47);
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        int  x;
        int  y;
        bit  last;
        bit  drain;
        int  gap;
    } vertex_t;

    typedef struct {
        logic signed [47:0] lb;
        logic signed [47:0] rb;
        logic signed [47:0] lt;
        logic signed [47:0] rt;
        logic signed [31:0] by;
        logic signed [31:0] ty;
        logic               last;
        logic [1:0]         status;
    } trap_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cpts_vertex_if vin();
    cpts_trap_if   tout();

    convex_polygon_trapezoid_split dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vin   (vin),
        .tout  (tout)
    );

    always #2 clk = ~clk;

    vertex_t pending[$];
    trap_t   trap_q[$];
    int      errors = 0;
    int      cycles = 0;
    int      gap_cnt = 0;
    int      stall = 0;
    bit      beat_taken = 0;
    bit      busy_mode = 0;
    bit      sink_busy = 0;

    int      vx[NVERT];
    int      vy[NVERT];
    int      vcount = 0;
    bit      overflow = 0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sat48(longint v);
        return v > X_HI ? X_HI : (v < X_LO ? X_LO : v);
    endfunction

    function automatic longint edge_at(int a, int b, longint yy);
        longint ax;
        longint dx;
        longint d;
        longint t;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        longint off;
        bit neg;
        ax = vx[a];
        dx = longint'(vx[b]) - ax;
        d = longint'(vy[b]) - vy[a];
        t = yy - vy[a];
        if (d == 0)
            return sat48(ax * (longint'(1) <<< FRAC));
        num = 128'(mag(dx));
        num = num * 128'(mag(t));
        num = num << FRAC;
        num = (num << 1) + 128'(mag(d));
        den = 128'(mag(d)) * 2;
        q = num / den;
        if (q > (128'd1 << 62))
            q = 128'd1 << 62;
        off = longint'(q[63:0]);
        neg = ((dx < 0) != (t < 0)) != (d < 0);
        return sat48(ax * (longint'(1) <<< FRAC) + (neg ? -off : off));
    endfunction

    function automatic bit turns_left(int a, int b, int p);
        logic signed [127:0] a1;
        logic signed [127:0] b1;
        logic signed [127:0] a2;
        logic signed [127:0] b2;
        logic signed [127:0] c;
        a1 = longint'(vx[b]) - vx[a];
        b1 = longint'(vy[p]) - vy[a];
        a2 = longint'(vy[b]) - vy[a];
        b2 = longint'(vx[p]) - vx[a];
        c = a1 * b1 - a2 * b2;
        return c > 0;
    endfunction

    function automatic int climb(int top, int n);
        int prv;
        prv = (top + n - 1) % n;
        return vy[prv] > vy[top] ? prv : (top + 1) % n;
    endfunction

    function automatic trap_t error_trap(logic [1:0] st);
        trap_t r;
        r = '{default: '0};
        r.last = 1'b1;
        r.status = st;
        return r;
    endfunction

    task automatic sweep_polygon(int n);
        int imin;
        int bot;
        int nxt;
        int dnx;
        int prv;
        int lbi;
        int lti;
        int rbi;
        int rti;
        int k;
        longint ymin;
        longint ytop;
        longint sweep;
        longint ynew;
        longint plx;
        longint prx;
        longint lx;
        longint rx;
        trap_t r;
        imin = 0;
        k = 0;
        ymin = vy[0];
        ytop = vy[0];
        for (int i = 1; i < n; i++)
        begin
            if (vy[i] > ytop) ytop = vy[i];
            if (vy[i] < ymin)
            begin
                ymin = vy[i];
                imin = i;
            end
        end
        bot = imin;
        if (vy[(imin + n - 1) % n] == ymin) bot = (imin + n - 1) % n;
        nxt = (bot + 1) % n;
        dnx = (bot + 2) % n;
        prv = (bot + n - 1) % n;
        if (vy[nxt] == ymin)
        begin
            if (vx[dnx] > vx[prv] || (vx[dnx] == vx[prv] && vx[nxt] > vx[bot]))
            begin
                lbi = bot; lti = prv; rbi = nxt; rti = dnx;
            end
            else
            begin
                lbi = nxt; lti = dnx; rbi = bot; rti = prv;
            end
        end
        else if (turns_left(prv, bot, nxt))
        begin
            lbi = bot; lti = prv; rbi = bot; rti = nxt;
        end
        else
        begin
            lbi = bot; lti = nxt; rbi = bot; rti = prv;
        end
        sweep = ymin;
        plx = sat48(longint'(vx[lbi]) * (longint'(1) <<< FRAC));
        prx = sat48(longint'(vx[rbi]) * (longint'(1) <<< FRAC));
        while (sweep < ytop && k < NVERT - 1)
        begin
            ynew = vy[lti] < vy[rti] ? vy[lti] : vy[rti];
            if (ynew <= sweep) break;
            lx = edge_at(lbi, lti, ynew);
            rx = edge_at(rbi, rti, ynew);
            r.lb = plx[47:0];
            r.rb = prx[47:0];
            r.lt = lx[47:0];
            r.rt = rx[47:0];
            r.by = sweep[31:0];
            r.ty = ynew[31:0];
            r.last = 1'b0;
            r.status = cpts_pkg::STATUS_OK;
            trap_q.insert(trap_q.size(), r);
            k++;
            plx = lx;
            prx = rx;
            sweep = ynew;
            if (vy[lti] == sweep)
            begin
                lbi = lti;
                lti = climb(lti, n);
            end
            if (vy[rti] == sweep)
            begin
                rbi = rti;
                rti = climb(rti, n);
            end
        end
        if (k > 0) trap_q[trap_q.size() - 1].last = 1'b1;
    endtask

    task automatic take_vertex(int x, int y, bit last);
        if (vcount < NVERT)
        begin
            vx[vcount] = x;
            vy[vcount] = y;
            vcount++;
        end
        else
            overflow = 1;
        if (last)
        begin
            if (overflow)
                trap_q.insert(trap_q.size(), error_trap(cpts_pkg::STATUS_OVERFLOW));
            else if (vcount < 3)
                trap_q.insert(trap_q.size(), error_trap(cpts_pkg::STATUS_TOO_FEW));
            else
                sweep_polygon(vcount);
            vcount = 0;
            overflow = 0;
        end
    endtask

    function automatic int pick_gap(bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (!busy || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic add_vertex(int x, int y, bit last, bit drain);
        vertex_t v;
        v.x = x;
        v.y = y;
        v.last = last;
        v.drain = drain;
        v.gap = pick_gap(busy_mode);
        pending.insert(pending.size(), v);
    endtask

    task automatic add_convex(int n, bit drain);
        longint cx;
        longint cy;
        longint rx;
        longint ry;
        int sel;
        int s;
        bit cw;
        real ang;
        int px[16];
        int py[16];
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            rx = $urandom_range(1, 20);
            ry = $urandom_range(1, 20);
        end
        else if (sel < 9)
        begin
            rx = $urandom_range(100, 1 << 20);
            ry = $urandom_range(100, 1 << 20);
        end
        else
        begin
            rx = $urandom_range(1 << 28, 1 << 30);
            ry = $urandom_range(1 << 28, 1 << 30);
        end
        cx = (sel == 9) ? 0 : longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        cy = (sel == 9) ? 0 : longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        for (int i = 0; i < n; i++)
        begin
            ang = 6.283185307179586 * (i + 0.8 * $urandom_range(0, 1000) / 1000.0) / n;
            px[i] = int'(cx + $rtoi(rx * $cos(ang)));
            py[i] = int'(cy + $rtoi(ry * $sin(ang)));
        end
        s = $urandom_range(0, n - 1);
        cw = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
        begin
            int j;
            j = cw ? (s + n - i) % n : (s + i) % n;
            add_vertex(px[j], py[j], i == n - 1, drain && i == 0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_taken <= 1'b0;
        else
        begin
            beat_taken <= vin.valid && vin.ready;
            if (vin.valid && vin.ready)
                take_vertex(vin.vertex_x, vin.vertex_y, vin.last_vertex);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            vin.valid <= 1'b0;
            vin.vertex_x <= '0;
            vin.vertex_y <= '0;
            vin.last_vertex <= 1'b0;
        end
        else if (!vin.valid || beat_taken)
        begin
            if (pending.size() == 0)
                vin.valid <= 1'b0;
            else if (gap_cnt < pending[0].gap)
            begin
                vin.valid <= 1'b0;
                gap_cnt <= gap_cnt + 1;
            end
            else if (pending[0].drain && trap_q.size() != 0)
                vin.valid <= 1'b0;
            else
            begin
                vin.valid <= 1'b1;
                vin.vertex_x <= pending[0].x;
                vin.vertex_y <= pending[0].y;
                vin.last_vertex <= pending[0].last;
                void'(pending.pop_front());
                gap_cnt <= 0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            tout.ready <= 1'b0;
        else if (stall > 0)
        begin
            tout.ready <= 1'b0;
            stall <= stall - 1;
        end
        else
        begin
            tout.ready <= 1'b1;
            stall <= pick_gap(sink_busy);
        end
        if (cycles % 3000 == 0) sink_busy <= $urandom_range(0, 1);
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && tout.valid && tout.ready)
        begin
            if (trap_q.size() == 0)
            begin
                $error("trapezoid beat with none expected");
                errors++;
            end
            else
            begin
                trap_t e;
                e = trap_q.pop_front();
                check_field("left_bottom_x", 64'(e.lb), 64'(tout.left_bottom_x));
                check_field("right_bottom_x", 64'(e.rb), 64'(tout.right_bottom_x));
                check_field("left_top_x", 64'(e.lt), 64'(tout.left_top_x));
                check_field("right_top_x", 64'(e.rt), 64'(tout.right_top_x));
                check_field("bottom_y", 64'(e.by), 64'(tout.bottom_y));
                check_field("top_y", 64'(e.ty), 64'(tout.top_y));
                check_field("last_trapezoid", 64'(e.last), 64'(tout.last_trapezoid));
                check_field("status", 64'(e.status), 64'(tout.status));
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int items;
        int n;
        int r;
        bit drain;
        bit overflow_done;
        vin.valid = 1'b0;
        vin.vertex_x = '0;
        vin.vertex_y = '0;
        vin.last_vertex = 1'b0;
        tout.ready = 1'b0;

        add_vertex(32'h8000_0000, 32'h8000_0000, 0, 0);
        add_vertex(32'h7fff_ffff, 32'h8000_0000, 0, 0);
        add_vertex(0, 32'h7fff_ffff, 1, 0);
        add_vertex(0, 32'h8000_0000, 0, 0);
        add_vertex(32'h8000_0000, 0, 0, 0);
        add_vertex(32'h7fff_ffff, 32'h7fff_ffff, 1, 0);
        add_vertex(0, 0, 0, 0);
        add_vertex(10, 0, 0, 0);
        add_vertex(10, 10, 0, 0);
        add_vertex(0, 10, 1, 0);
        add_vertex(1, 5, 0, 0);
        add_vertex(7, 5, 0, 0);
        add_vertex(3, 5, 1, 0);
        add_vertex(-1, -1, 1, 0);
        add_vertex(4, 4, 0, 0);
        add_vertex(-4, 9, 1, 0);
        add_vertex(-3, 0, 0, 1);
        add_vertex(2, -7, 0, 0);
        add_vertex(9, 1, 0, 0);
        add_vertex(5, 8, 0, 0);
        add_vertex(-6, 6, 1, 0);

        items = 0;
        overflow_done = 0;
        while (items < 200)
        begin
            busy_mode = $urandom_range(0, 3) != 0;
            drain = (items == 0) || ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (!overflow_done && items > 80)
            begin
                for (int i = 0; i <= NVERT; i++)
                    add_vertex($urandom, $urandom, i == NVERT, 0);
                items += NVERT + 1;
                overflow_done = 1;
            end
            else if (r < 70)
            begin
                n = $urandom_range(3, 10);
                add_convex(n, drain);
                items += n;
            end
            else if (r < 85)
            begin
                n = $urandom_range(3, 6);
                for (int i = 0; i < n; i++)
                    add_vertex($urandom, $urandom, i == n - 1, drain && i == 0);
                items += n;
            end
            else if (r < 93)
            begin
                n = $urandom_range(1, 2);
                for (int i = 0; i < n; i++)
                    add_vertex($urandom, $urandom, i == n - 1, 0);
                items += n;
            end
            else
            begin
                int yy;
                yy = $urandom;
                n = $urandom_range(3, 5);
                for (int i = 0; i < n; i++)
                    add_vertex($urandom, yy, i == n - 1, 0);
                items += n;
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || vin.valid || trap_q.size() != 0)
            @(posedge clk);
        repeat (1500) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
design/cpts_pkg.sv
design/cpts_if.sv
design/cpts_ram.sv
design/cpts_divider.sv
design/cpts_front.sv
design/cpts_back.sv
design/convex_polygon_trapezoid_split.sv
verif/testbench.sv
